// ===== sv/brute_force_assignment_solver_defines.svh =====
// Assertion macros shared by the checker of the brute-force assignment solver.
// No dependencies; each macro expects clk and rst to be visible where it is used.
`ifndef BRUTE_FORCE_ASSIGNMENT_SOLVER_DEFINES_SVH
`define BRUTE_FORCE_ASSIGNMENT_SOLVER_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define BFAS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define BFAS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bfas_pkg.sv =====
// Package of the brute-force assignment solver: port widths, defaults and control structs.
// Has no dependencies; used by the top level, bfas_perm_unit and bfas_acc_unit.
`default_nettype none

package bfas_pkg;

  localparam int MAX_SIZE_DEF  = 8;
  localparam int COST_BITS_DEF = 16;

  localparam int IDX_PORT_W  = 3;
  localparam int COST_PORT_W = 16;
  localparam int TOTAL_W     = 19;
  localparam int COUNT_W     = 16;
  localparam int SIZE_CFG_W  = 4;

  localparam logic [SIZE_CFG_W-1:0] SIZE_RESET = 4'd8;

  typedef struct packed {
    logic init;
    logic advance;
  } perm_ctrl_t;

  typedef struct packed {
    logic clear;
    logic add;
    logic commit;
    logic first;
  } acc_ctrl_t;

  function automatic int factorial(input int n);
    int f;
    f = 1;
    for (int i = 2; i <= n; i++) begin
      f = f * i;
    end
    return f;
  endfunction

endpackage

`default_nettype wire

// ===== sv/bfas_cost_ram.sv =====
// Cost matrix store of the brute-force assignment solver: one write port, one registered read.
// No package dependency.
`default_nettype none

module bfas_cost_ram #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 16
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/bfas_perm_unit.sv =====
// Permutation register with a next-permutation step in lexicographic order.
// Depends on bfas_pkg for the control struct.
`default_nettype none

module bfas_perm_unit #(
  parameter int MAX_SIZE = 8,
  parameter int IDX_W    = 3,
  parameter int SIZE_W   = 4
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire bfas_pkg::perm_ctrl_t               ctrl,
  input  wire logic [SIZE_W-1:0]                  n,
  output logic      [MAX_SIZE-1:0][IDX_W-1:0]     perm,
  output logic                                    has_next
);

  logic [MAX_SIZE-2:0]              asc;
  logic [IDX_W-1:0]                 pivot;
  logic [IDX_W-1:0]                 swap_j;
  logic [IDX_W-1:0]                 piv_val;
  logic [MAX_SIZE-1:0][IDX_W-1:0]   perm_next;

  // The pivot is the rightmost place inside the active length that rises.
  always_comb begin
    pivot = '0;
    for (int k = 0; k < MAX_SIZE - 1; k++) begin
      asc[k] = (k + 1 < int'(n)) && (perm[k] < perm[k+1]);
      if (asc[k]) begin
        pivot = IDX_W'(k);
      end
    end
    has_next = |asc;
  end

  assign piv_val = perm[pivot];

  // The suffix after the pivot falls, so the rightmost larger entry is the successor.
  always_comb begin
    swap_j = pivot;
    for (int m = 0; m < MAX_SIZE; m++) begin
      if ((m < int'(n)) && (m > int'(pivot)) && (perm[m] > piv_val)) begin
        swap_j = IDX_W'(m);
      end
    end
  end

  // Swap pivot and successor, then reverse the suffix, all in one step.
  always_comb begin
    int src;
    for (int k = 0; k < MAX_SIZE; k++) begin
      src = int'(n) + int'(pivot) - k;
      if ((k > int'(pivot)) && (k < int'(n))) begin
        if (IDX_W'(src) == swap_j) begin
          perm_next[k] = piv_val;
        end else begin
          perm_next[k] = perm[IDX_W'(src)];
        end
      end else if (k == int'(pivot)) begin
        perm_next[k] = perm[swap_j];
      end else begin
        perm_next[k] = perm[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.init) begin
      for (int k = 0; k < MAX_SIZE; k++) begin
        perm[k] <= IDX_W'(k);
      end
    end else if (ctrl.advance && has_next) begin
      perm <= perm_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/bfas_acc_unit.sv =====
// Shared adder and comparator: sums one permutation's costs and keeps the best total.
// Depends on bfas_pkg for the control struct.
`default_nettype none

module bfas_acc_unit #(
  parameter int COST_BITS = 16,
  parameter int SUM_W     = 19
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire bfas_pkg::acc_ctrl_t    ctrl,
  input  wire logic [COST_BITS-1:0]   rd_data,
  output logic      [SUM_W-1:0]       best_total,
  output logic                        take
);

  logic [SUM_W-1:0] total;

  // Ties keep the earlier permutation; the first one is always taken.
  assign take = ctrl.commit && (ctrl.first || (total < best_total));

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      total <= '0;
    end else if (ctrl.add) begin
      total <= total + SUM_W'(rd_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_total <= '1;
    end else if (take) begin
      best_total <= total;
    end
  end

endmodule

`default_nettype wire

// ===== sv/brute_force_assignment_solver.sv =====
// Top level of the brute-force assignment solver; instantiates bfas_cost_ram,
// bfas_perm_unit and bfas_acc_unit, and uses bfas_pkg for widths and control structs.
`default_nettype none

// The solver takes a cost matrix one entry per input word (row = person, col = job)
// and accepts one such word every cycle while it is loading. Entries whose row or
// column lies at or beyond MAX_SIZE are dropped. The word flagged with last is stored
// like any other and then starts an exhaustive search over all n! job orders, where n
// is problem_size clamped to the range one to MAX_SIZE. Every cost of the active
// n-by-n square must have been written before the search starts. The search reads one
// cost entry per cycle through the single read port of the cost store into one shared
// adder, so each permutation spends its n reads in the read state, then passes a tally
// state that finishes the sum and a next state that compares, updates the best and
// steps to the next permutation. The input is stalled from the last word until every
// result has gone. Afterwards n result words leave in person order, at most one per
// cycle, each carrying the person, the job given to that person, the lowest total (the
// earliest permutation in lexicographic order wins a tie) and the number of
// permutations tried; last_res marks the final person. problem_size is written through
// problem_size_we and may only change while the block is loading.

module brute_force_assignment_solver #(
  parameter int MAX_SIZE  = bfas_pkg::MAX_SIZE_DEF,
  parameter int COST_BITS = bfas_pkg::COST_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 problem_size_we,
  input  wire logic [bfas_pkg::SIZE_CFG_W-1:0]      problem_size,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [bfas_pkg::IDX_PORT_W-1:0]      row,
  input  wire logic [bfas_pkg::IDX_PORT_W-1:0]      col,
  input  wire logic [bfas_pkg::COST_PORT_W-1:0]     cost,
  input  wire logic                                 last,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [bfas_pkg::IDX_PORT_W-1:0]           person,
  output logic [bfas_pkg::IDX_PORT_W-1:0]           job,
  output logic [bfas_pkg::TOTAL_W-1:0]              min_total,
  output logic [bfas_pkg::COUNT_W-1:0]              perm_count,
  output logic                                      last_res
);

  localparam int IDX_W    = $clog2(MAX_SIZE);
  localparam int SIZE_W   = $clog2(MAX_SIZE + 1);
  localparam int DEPTH    = MAX_SIZE * MAX_SIZE;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int SUM_W    = COST_BITS + $clog2(MAX_SIZE);
  localparam int CNT_W    = $clog2(bfas_pkg::factorial(MAX_SIZE) + 1);
  localparam int PORT_W   = bfas_pkg::IDX_PORT_W;
  localparam int TOTAL_W  = bfas_pkg::TOTAL_W;
  localparam int COUNT_W  = bfas_pkg::COUNT_W;

  typedef enum logic [4:0] {
    ST_LOAD  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_TALLY = 5'b00100,
    ST_NEXT  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t                          state;
  state_t                          state_next;
  logic [bfas_pkg::SIZE_CFG_W-1:0] size_cfg;
  logic [SIZE_W-1:0]               n;
  logic [SIZE_W-1:0]               n_eff;
  logic [IDX_W-1:0]                k;
  logic                            rd_valid;
  logic [CNT_W-1:0]                perm_counter;
  logic [MAX_SIZE-1:0][IDX_W-1:0]  best_perm;
  logic [IDX_W-1:0]                emit_idx;

  logic                            in_take;
  logic                            start;
  logic                            entry_ok;
  logic                            wr_en;
  logic [ADDR_W-1:0]               wr_addr;
  logic                            rd_en;
  logic [ADDR_W-1:0]               rd_addr;
  logic [COST_BITS-1:0]            rd_data;
  logic                            read_done;
  logic                            emit_done;

  bfas_pkg::perm_ctrl_t            perm_ctrl;
  bfas_pkg::acc_ctrl_t             acc_ctrl;
  logic [MAX_SIZE-1:0][IDX_W-1:0]  perm;
  logic                            has_next;
  logic [SUM_W-1:0]                best_total;
  logic                            take;

  // Configuration register; the user must write it only while the block is idle, as the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      size_cfg <= bfas_pkg::SIZE_RESET;
    end else if (problem_size_we) begin
      size_cfg <= problem_size;
    end
  end

  // A size of zero counts as one, and anything above MAX_SIZE as MAX_SIZE.
  always_comb begin
    if (size_cfg == '0) begin
      n_eff = SIZE_W'(1);
    end else if (int'(size_cfg) > MAX_SIZE) begin
      n_eff = SIZE_W'(MAX_SIZE);
    end else begin
      n_eff = SIZE_W'(size_cfg);
    end
  end

  // Loading side: words are taken only while the sequencer waits in the load state.
  assign in_stall = (state != ST_LOAD);
  assign in_take  = in_valid && !in_stall;
  assign start    = in_take && last;
  assign entry_ok = (int'(row) < MAX_SIZE) && (int'(col) < MAX_SIZE);
  assign wr_en    = in_take && entry_ok;
  assign wr_addr  = ADDR_W'(row) * ADDR_W'(MAX_SIZE) + ADDR_W'(col);

  // Search side: person k of the current permutation costs entry (k, perm[k]).
  assign rd_en     = (state == ST_READ);
  assign rd_addr   = ADDR_W'(k) * ADDR_W'(MAX_SIZE) + ADDR_W'(perm[k]);
  assign read_done = (SIZE_W'(k) == n - SIZE_W'(1));
  assign emit_done = (SIZE_W'(emit_idx) == n - SIZE_W'(1));

  bfas_cost_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (COST_BITS)
  ) u_cost_ram (
    .clk     (clk),
    .we      (wr_en),
    .wr_addr (wr_addr),
    .wr_data (COST_BITS'(cost)),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The permutation starts at the identity with every search and steps once the
  // current one has been compared.
  assign perm_ctrl.init    = start;
  assign perm_ctrl.advance = (state == ST_NEXT);

  bfas_perm_unit #(
    .MAX_SIZE (MAX_SIZE),
    .IDX_W    (IDX_W),
    .SIZE_W   (SIZE_W)
  ) u_perm_unit (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (perm_ctrl),
    .n        (n),
    .perm     (perm),
    .has_next (has_next)
  );

  // Read data is registered and arrives in the cycle after its address, hence the delayed add.
  assign acc_ctrl.clear  = start || (state == ST_NEXT);
  assign acc_ctrl.add    = rd_valid;
  assign acc_ctrl.commit = (state == ST_NEXT);
  assign acc_ctrl.first  = (perm_counter == '0);

  bfas_acc_unit #(
    .COST_BITS (COST_BITS),
    .SUM_W     (SUM_W)
  ) u_acc_unit (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (acc_ctrl),
    .rd_data    (rd_data),
    .best_total (best_total),
    .take       (take)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (start) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (read_done) begin
          state_next = ST_TALLY;
        end
      end
      ST_TALLY: begin
        state_next = ST_NEXT;
      end
      ST_NEXT: begin
        state_next = has_next ? ST_READ : ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_stall && emit_done) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      rd_valid     <= 1'b0;
      k            <= '0;
      n            <= SIZE_W'(MAX_SIZE);
      perm_counter <= '0;
      emit_idx     <= '0;
      out_valid    <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= rd_en;
      if (start) begin
        n            <= n_eff;
        k            <= '0;
        perm_counter <= '0;
      end
      if (state == ST_READ) begin
        k <= read_done ? '0 : k + IDX_W'(1);
      end
      if (state == ST_NEXT) begin
        perm_counter <= perm_counter + CNT_W'(1);
        if (!has_next) begin
          out_valid <= 1'b1;
          emit_idx  <= '0;
        end
      end
      if ((state == ST_EMIT) && out_valid && !out_stall) begin
        if (emit_done) begin
          out_valid <= 1'b0;
        end else begin
          emit_idx <= emit_idx + IDX_W'(1);
        end
      end
    end
  end

  // The best order is copied whole when a permutation is taken: the first one, or one that beats the one held.
  always_ff @(posedge clk) begin
    if (take) begin
      best_perm <= perm;
    end
  end

  assign person     = PORT_W'(emit_idx);
  assign job        = PORT_W'(best_perm[emit_idx]);
  assign min_total  = TOTAL_W'(best_total);
  assign perm_count = COUNT_W'(perm_counter);
  assign last_res   = emit_done;

endmodule

`default_nettype wire

// ===== sv/bfas_checker.sv =====
// Port-level checker for the brute-force assignment solver, bound to the top level.
// Depends on brute_force_assignment_solver_defines.svh for the assertion macros.
`default_nettype none

`include "brute_force_assignment_solver_defines.svh"

module bfas_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        last,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  person,
  input wire logic [2:0]  job,
  input wire logic [18:0] min_total,
  input wire logic [15:0] perm_count,
  input wire logic        last_res
);

  // No word is loaded while results are still going out.
  `BFAS_ASSERT_IMP(a_no_load_while_emit, out_valid, in_stall, "input taken during results")

  // A stalled result holds every field.
  `BFAS_ASSERT_NXT(a_stall_holds, out_valid && out_stall, out_valid && $stable(person) && $stable(job) && $stable(min_total) && $stable(perm_count) && $stable(last_res), "stalled result changed")

  // Persons follow one another with the same total and count until the final one.
  `BFAS_ASSERT_NXT(a_person_order, out_valid && !out_stall && !last_res, out_valid && (person == 3'($past(person) + 3'd1)) && $stable(min_total) && $stable(perm_count), "result order broken")

  // The final result ends the burst.
  `BFAS_ASSERT_NXT(a_burst_end, out_valid && !out_stall && last_res, !out_valid, "result after final person")

  // A final matrix entry starts the search, so the input stalls next.
  `BFAS_ASSERT_NXT(a_search_starts, in_valid && !in_stall && last, in_stall, "input not stalled after final entry")

endmodule

bind brute_force_assignment_solver bfas_checker u_bfas_checker (.*);

`default_nettype wire
